>>> sv/eiec_pkg.sv
// Types and constants shared by the external interrupt edge controller.
package eiec_pkg;

    localparam int unsigned LINE_W = 19;
    localparam int unsigned GPIO_PINS = 12;
    localparam int unsigned SEL_WORDS = 3;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_GPIO  = 2'd2,
        MODE_LINE  = 2'd3
    } t_mode;

    localparam logic [11:0] OFF_RISE  = 12'h000;
    localparam logic [11:0] OFF_FALL  = 12'h004;
    localparam logic [11:0] OFF_SWT   = 12'h008;
    localparam logic [11:0] OFF_PEND  = 12'h00C;
    localparam logic [11:0] OFF_SEL0  = 12'h060;
    localparam logic [11:0] OFF_SEL1  = 12'h064;
    localparam logic [11:0] OFF_SEL2  = 12'h068;
    localparam logic [11:0] OFF_IMASK = 12'h080;
    localparam logic [11:0] OFF_EMASK = 12'h084;

    localparam logic [2:0] ACCESS_WORD = 3'd4;

    localparam logic [LINE_W-1:0] GROUP0 = 19'h00003;
    localparam logic [LINE_W-1:0] GROUP1 = 19'h0000C;
    localparam logic [LINE_W-1:0] GROUP2 = 19'h0FFF0;
    localparam logic [LINE_W-1:0] GROUP3 = 19'h60000;

    typedef struct packed {
        t_mode       mode;
        logic [11:0] offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic [3:0]  port;
        logic [4:0]  line_index;
        logic        old_level;
        logic        new_level;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic [3:0]  irq_request;
    } t_out_item;

endpackage

>>> sv/eiec_if.sv
// Valid/ready channel interfaces for input and result items.
interface eiec_in_if;
    logic                valid;
    logic                ready;
    eiec_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface eiec_out_if;
    logic                valid;
    logic                ready;
    eiec_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/external_interrupt_edge_controller.sv
// External interrupt edge controller: register file, edge detect and result buffer.
//
// Usage:
//   i_in carries items: bus read, bus write, gpio pin edge or direct line edge.
//   o_out returns one result per item: read_data, access_ok and the grouped
//   interrupt request taken from pending AND mask after the item is applied.
//   An item is accepted when valid and ready are both high at i_clk.
// Result: registered into the output register, or into the skid entry while that is full.
// Throughput: one item per cycle while the skid entry is empty; the register read-modify-write of the
//   pending bits completes in the accept cycle.
// Stall: a two-entry result buffer decouples the channels. With the output
//   register full and unread, one more item is taken into the skid entry;
//   i_in.ready drops only while the skid entry is occupied.
// Reset: i_rst_n low (synchronous) clears all enables, trigger, pending,
//   port selection words and masks, and empties the result buffer.
// Edges: gpio pins 0-11 route through the port selection nibbles; direct
//   lines cover 0-18. Line 16 may pend but drives no request bit.
module external_interrupt_edge_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    eiec_in_if.sink             i_in,
    eiec_out_if.source          o_out
);

    localparam int unsigned LW = eiec_pkg::LINE_W;

    logic [LW-1:0] r_rise, r_fall, r_swt, r_pend, r_imask, r_emask;
    logic [31:0]   r_sel [eiec_pkg::SEL_WORDS];

    logic [LW-1:0] n_rise, n_fall, n_swt, n_pend, n_imask, n_emask;
    logic [31:0]   n_sel [eiec_pkg::SEL_WORDS];

    eiec_pkg::t_out_item r_out, r_skid, n_res;
    logic                r_out_vld, r_skid_vld;

    eiec_pkg::t_in_item  in_item;
    logic                acc, take;
    logic                bus_op, bus_ok, edge_rise, edge_fall;
    logic [31:0]         sel_word;
    logic [3:0]          sel_nib;
    logic [LW-1:0]       line_bit, pend_masked;
    logic                line_hit;

    assign in_item     = i_in.payload;
    assign i_in.ready  = !r_skid_vld;
    assign acc         = i_in.valid && i_in.ready;
    assign take        = o_out.valid && o_out.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.payload = r_out;

    always_comb begin
        case (in_item.line_index[3:2])
            2'd0:    sel_word = r_sel[0];
            2'd1:    sel_word = r_sel[1];
            default: sel_word = r_sel[2];
        endcase
        sel_nib = sel_word[{in_item.line_index[1:0], 3'b000} +: 4];
    end

    always_comb begin
        bus_op    = (in_item.mode == eiec_pkg::MODE_READ) ||
                    (in_item.mode == eiec_pkg::MODE_WRITE);
        bus_ok    = (in_item.access_size == eiec_pkg::ACCESS_WORD) &&
                    (in_item.offset[1:0] == 2'b00);
        edge_rise = !in_item.old_level && in_item.new_level;
        edge_fall = in_item.old_level && !in_item.new_level;
        line_bit  = LW'(1) << in_item.line_index;
        line_hit  = 1'b0;

        n_rise  = r_rise;
        n_fall  = r_fall;
        n_swt   = r_swt;
        n_pend  = r_pend;
        n_imask = r_imask;
        n_emask = r_emask;
        n_sel   = r_sel;

        n_res.read_data = 32'd0;
        n_res.access_ok = 1'b1;

        case (in_item.mode)
            eiec_pkg::MODE_READ: begin
                if (!bus_ok) begin
                    n_res.access_ok = 1'b0;
                end else begin
                    case (in_item.offset)
                        eiec_pkg::OFF_RISE:  n_res.read_data = 32'(r_rise);
                        eiec_pkg::OFF_FALL:  n_res.read_data = 32'(r_fall);
                        eiec_pkg::OFF_SWT:   n_res.read_data = 32'(r_swt);
                        eiec_pkg::OFF_PEND:  n_res.read_data = 32'(r_pend);
                        eiec_pkg::OFF_SEL0:  n_res.read_data = r_sel[0];
                        eiec_pkg::OFF_SEL1:  n_res.read_data = r_sel[1];
                        eiec_pkg::OFF_SEL2:  n_res.read_data = r_sel[2];
                        eiec_pkg::OFF_IMASK: n_res.read_data = 32'(r_imask);
                        eiec_pkg::OFF_EMASK: n_res.read_data = 32'(r_emask);
                        default:             n_res.read_data = 32'd0;
                    endcase
                end
            end
            eiec_pkg::MODE_WRITE: begin
                if (!bus_ok) begin
                    n_res.access_ok = 1'b0;
                end else begin
                    case (in_item.offset)
                        eiec_pkg::OFF_RISE:  n_rise = in_item.write_data[LW-1:0];
                        eiec_pkg::OFF_FALL:  n_fall = in_item.write_data[LW-1:0];
                        eiec_pkg::OFF_SWT: begin
                            n_swt  = in_item.write_data[LW-1:0];
                            n_pend = r_pend | in_item.write_data[LW-1:0];
                        end
                        eiec_pkg::OFF_PEND:  n_pend = r_pend & ~in_item.write_data[LW-1:0];
                        eiec_pkg::OFF_SEL0:  n_sel[0] = in_item.write_data;
                        eiec_pkg::OFF_SEL1:  n_sel[1] = in_item.write_data;
                        eiec_pkg::OFF_SEL2:  n_sel[2] = in_item.write_data;
                        eiec_pkg::OFF_IMASK: n_imask = in_item.write_data[LW-1:0];
                        eiec_pkg::OFF_EMASK: n_emask = in_item.write_data[LW-1:0];
                        default: ;
                    endcase
                end
            end
            eiec_pkg::MODE_GPIO: begin
                line_hit = (32'(in_item.line_index) < eiec_pkg::GPIO_PINS) &&
                           (sel_nib == in_item.port);
            end
            default: begin
                line_hit = 32'(in_item.line_index) < LW;
            end
        endcase

        if (!bus_op && line_hit) begin
            if ((edge_rise && (r_rise & line_bit) != '0) ||
                (edge_fall && (r_fall & line_bit) != '0)) begin
                n_pend = r_pend | line_bit;
            end
        end

        pend_masked = n_pend & n_imask;
        n_res.irq_request = {(pend_masked & eiec_pkg::GROUP3) != '0,
                             (pend_masked & eiec_pkg::GROUP2) != '0,
                             (pend_masked & eiec_pkg::GROUP1) != '0,
                             (pend_masked & eiec_pkg::GROUP0) != '0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_swt   <= '0;
            r_pend  <= '0;
            r_imask <= '0;
            r_emask <= '0;
            for (int i = 0; i < int'(eiec_pkg::SEL_WORDS); i++) begin
                r_sel[i] <= '0;
            end
        end else if (acc) begin
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_swt   <= n_swt;
            r_pend  <= n_pend;
            r_imask <= n_imask;
            r_emask <= n_emask;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end else if (acc) begin
                    r_out <= n_res;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end else if (acc) begin
                if (r_out_vld) begin
                    r_skid     <= n_res;
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out     <= n_res;
                    r_out_vld <= 1'b1;
                end
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without output entry");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_vld && r_skid_vld))
        else $error("input stalled with result buffer not full");

    a_bad_access_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.access_ok) |-> (o_out.payload.read_data == 32'd0))
        else $error("rejected access returned data");

    a_pend_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_item.mode == eiec_pkg::MODE_WRITE && bus_ok &&
         in_item.offset == eiec_pkg::OFF_PEND && in_item.write_data[LW-1:0] == '1)
        |=> (r_pend == '0))
        else $error("pending not cleared by full write-one-to-clear");

    a_bad_access_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && bus_op && !bus_ok) |=> ($stable(r_pend) && $stable(r_rise) && $stable(r_imask)))
        else $error("rejected access changed state");

endmodule

>>> bench/eiec_result_checker.sv
// Result checker for the external interrupt edge controller: predicts and compares each result.
`timescale 1ns / 1ps

module eiec_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    eiec_in_if   i_in,
    eiec_out_if  i_out,
    output int   o_fail_count,
    output int   o_awaited
);

    logic [eiec_pkg::LINE_W-1:0] rise_en;
    logic [eiec_pkg::LINE_W-1:0] fall_en;
    logic [eiec_pkg::LINE_W-1:0] swt_reg;
    logic [eiec_pkg::LINE_W-1:0] pend;
    logic [eiec_pkg::LINE_W-1:0] imask;
    logic [eiec_pkg::LINE_W-1:0] emask;
    logic [31:0]                 sel_word [eiec_pkg::SEL_WORDS];

    eiec_pkg::t_out_item awaited_results [$];
    int                  fail_total = 0;

    function automatic void mark_line(input logic [4:0] idx, input logic old_l,
                                      input logic new_l);
        logic [eiec_pkg::LINE_W-1:0] hit;
        hit = eiec_pkg::LINE_W'(1) << idx;
        if (!old_l && new_l && (rise_en & hit) != '0) begin
            pend = pend | hit;
        end
        if (old_l && !new_l && (fall_en & hit) != '0) begin
            pend = pend | hit;
        end
    endfunction

    task automatic compute_response(input eiec_pkg::t_in_item it,
                                    output eiec_pkg::t_out_item res);
        logic [3:0]                  sel;
        logic [eiec_pkg::LINE_W-1:0] live;
        res = '0;
        res.access_ok = 1'b1;
        if (it.mode == eiec_pkg::MODE_READ || it.mode == eiec_pkg::MODE_WRITE) begin
            if (it.access_size != eiec_pkg::ACCESS_WORD || it.offset[1:0] != 2'b00) begin
                res.access_ok = 1'b0;
            end else if (it.mode == eiec_pkg::MODE_READ) begin
                case (it.offset)
                    eiec_pkg::OFF_RISE:  res.read_data = 32'(rise_en);
                    eiec_pkg::OFF_FALL:  res.read_data = 32'(fall_en);
                    eiec_pkg::OFF_SWT:   res.read_data = 32'(swt_reg);
                    eiec_pkg::OFF_PEND:  res.read_data = 32'(pend);
                    eiec_pkg::OFF_SEL0:  res.read_data = sel_word[0];
                    eiec_pkg::OFF_SEL1:  res.read_data = sel_word[1];
                    eiec_pkg::OFF_SEL2:  res.read_data = sel_word[2];
                    eiec_pkg::OFF_IMASK: res.read_data = 32'(imask);
                    eiec_pkg::OFF_EMASK: res.read_data = 32'(emask);
                    default:             res.read_data = '0;
                endcase
            end else begin
                case (it.offset)
                    eiec_pkg::OFF_RISE:  rise_en = it.write_data[eiec_pkg::LINE_W-1:0];
                    eiec_pkg::OFF_FALL:  fall_en = it.write_data[eiec_pkg::LINE_W-1:0];
                    eiec_pkg::OFF_SWT: begin
                        swt_reg = it.write_data[eiec_pkg::LINE_W-1:0];
                        pend = pend | swt_reg;
                    end
                    eiec_pkg::OFF_PEND:  pend = pend & ~it.write_data[eiec_pkg::LINE_W-1:0];
                    eiec_pkg::OFF_SEL0:  sel_word[0] = it.write_data;
                    eiec_pkg::OFF_SEL1:  sel_word[1] = it.write_data;
                    eiec_pkg::OFF_SEL2:  sel_word[2] = it.write_data;
                    eiec_pkg::OFF_IMASK: imask = it.write_data[eiec_pkg::LINE_W-1:0];
                    eiec_pkg::OFF_EMASK: emask = it.write_data[eiec_pkg::LINE_W-1:0];
                    default: ;
                endcase
            end
        end else if (it.old_level != it.new_level) begin
            if (it.mode == eiec_pkg::MODE_GPIO) begin
                if (it.line_index < eiec_pkg::GPIO_PINS) begin
                    sel = sel_word[it.line_index[3:2]][{it.line_index[1:0], 3'b000} +: 4];
                    if (sel == it.port) begin
                        mark_line(it.line_index, it.old_level, it.new_level);
                    end
                end
            end else if (it.line_index < eiec_pkg::LINE_W) begin
                mark_line(it.line_index, it.old_level, it.new_level);
            end
        end
        live = pend & imask;
        res.irq_request = {(live & eiec_pkg::GROUP3) != '0, (live & eiec_pkg::GROUP2) != '0,
                           (live & eiec_pkg::GROUP1) != '0, (live & eiec_pkg::GROUP0) != '0};
    endtask

    always @(posedge i_clk) begin
        eiec_pkg::t_out_item want;
        eiec_pkg::t_out_item got;
        if (!i_rst_n) begin
            rise_en = '0;
            fall_en = '0;
            swt_reg = '0;
            pend    = '0;
            imask   = '0;
            emask   = '0;
            for (int w = 0; w < eiec_pkg::SEL_WORDS; w++) begin
                sel_word[w] = '0;
            end
            awaited_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = i_out.payload;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, got);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, got.read_data);
                        fail_total++;
                    end
                    if (got.access_ok !== want.access_ok) begin
                        $display("%0t: access_ok expected %b actual %b",
                                 $time, want.access_ok, got.access_ok);
                        fail_total++;
                    end
                    if (got.irq_request !== want.irq_request) begin
                        $display("%0t: irq_request expected %h actual %h",
                                 $time, want.irq_request, got.irq_request);
                        fail_total++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                compute_response(i_in.payload, want);
                awaited_results.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_awaited    <= awaited_results.size();
    end

endmodule

>>> bench/tb_external_interrupt_edge_controller.sv
// Testbench top for the external interrupt edge controller: stimulus, handshake idling, verdict.
`timescale 1ns / 1ps

module tb_external_interrupt_edge_controller;

    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   awaited;
    int   sent_count = 0;
    logic steady = 1'b0;
    logic [31:0] sel_shadow [eiec_pkg::SEL_WORDS];

    eiec_in_if  in_ch ();
    eiec_out_if out_ch ();

    external_interrupt_edge_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    eiec_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (steady || $urandom_range(1, 0) == 0) begin
            return 0;
        end
        return $urandom_range(14, 0);
    endfunction

    function automatic eiec_pkg::t_in_item noise_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(eiec_pkg::t_in_item)-1:0];
    endfunction

    task automatic send_item(input eiec_pkg::t_in_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        if (it.mode == eiec_pkg::MODE_WRITE && it.access_size == eiec_pkg::ACCESS_WORD) begin
            case (it.offset)
                eiec_pkg::OFF_SEL0: sel_shadow[0] = it.write_data;
                eiec_pkg::OFF_SEL1: sel_shadow[1] = it.write_data;
                eiec_pkg::OFF_SEL2: sel_shadow[2] = it.write_data;
                default: ;
            endcase
        end
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        if (sent_count % 100 == 0) begin
            steady = ($urandom_range(2, 0) == 0);
        end
    endtask

    task automatic bus_access(input eiec_pkg::t_mode m, input logic [11:0] off,
                              input logic [2:0] size, input logic [31:0] data);
        eiec_pkg::t_in_item it;
        it = noise_item();
        it.mode        = m;
        it.offset      = off;
        it.access_size = size;
        it.write_data  = data;
        send_item(it);
    endtask

    task automatic line_change(input eiec_pkg::t_mode m, input logic [4:0] idx,
                               input logic [3:0] prt, input logic old_l, input logic new_l);
        eiec_pkg::t_in_item it;
        it = noise_item();
        it.mode       = m;
        it.line_index = idx;
        it.port       = prt;
        it.old_level  = old_l;
        it.new_level  = new_l;
        send_item(it);
    endtask

    function automatic eiec_pkg::t_in_item random_item();
        eiec_pkg::t_in_item it;
        int pick;
        it = noise_item();
        if ($urandom_range(9, 0) == 0) begin
            return it;
        end
        pick = $urandom_range(19, 0);
        it.mode = (pick < 5) ? eiec_pkg::MODE_READ :
                  (pick < 11) ? eiec_pkg::MODE_WRITE :
                  (pick < 15) ? eiec_pkg::MODE_GPIO : eiec_pkg::MODE_LINE;
        case (it.mode)
            eiec_pkg::MODE_READ, eiec_pkg::MODE_WRITE: begin
                if ($urandom_range(9, 0) != 0) begin
                    it.access_size = eiec_pkg::ACCESS_WORD;
                end
                case ($urandom_range(11, 0))
                    0: it.offset = eiec_pkg::OFF_RISE;
                    1: it.offset = eiec_pkg::OFF_FALL;
                    2: it.offset = eiec_pkg::OFF_SWT;
                    3: it.offset = eiec_pkg::OFF_PEND;
                    4: it.offset = eiec_pkg::OFF_SEL0;
                    5: it.offset = eiec_pkg::OFF_SEL1;
                    6: it.offset = eiec_pkg::OFF_SEL2;
                    7: it.offset = eiec_pkg::OFF_IMASK;
                    8: it.offset = eiec_pkg::OFF_EMASK;
                    9: it.offset[1:0] = 2'b00;
                    default: ;
                endcase
                if ((it.offset == eiec_pkg::OFF_PEND || it.offset == eiec_pkg::OFF_SWT) &&
                    $urandom_range(1, 0) != 0) begin
                    it.write_data = it.write_data & $urandom & $urandom;
                end
            end
            eiec_pkg::MODE_GPIO: begin
                if ($urandom_range(9, 0) != 0) begin
                    it.line_index = 5'($urandom_range(11, 0));
                    if ($urandom_range(3, 0) != 0) begin
                        it.port = sel_shadow[it.line_index[3:2]]
                                            [{it.line_index[1:0], 3'b000} +: 4];
                    end
                end
            end
            default: begin
                if ($urandom_range(9, 0) != 0) begin
                    it.line_index = 5'($urandom_range(18, 0));
                end
            end
        endcase
        if ($urandom_range(7, 0) != 0) begin
            it.new_level = ~it.old_level;
        end
        return it;
    endfunction

    initial begin
        for (int w = 0; w < eiec_pkg::SEL_WORDS; w++) begin
            sel_shadow[w] = '0;
        end
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        bus_access(eiec_pkg::MODE_READ, eiec_pkg::OFF_PEND, eiec_pkg::ACCESS_WORD, 32'h0);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_RISE, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_FALL, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_IMASK, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_READ, eiec_pkg::OFF_RISE, eiec_pkg::ACCESS_WORD, 32'h0);
        line_change(eiec_pkg::MODE_LINE, 5'd0, 4'd0, 1'b0, 1'b1);
        line_change(eiec_pkg::MODE_LINE, 5'd18, 4'd0, 1'b1, 1'b0);
        line_change(eiec_pkg::MODE_LINE, 5'd16, 4'd15, 1'b0, 1'b1);
        line_change(eiec_pkg::MODE_LINE, 5'd19, 4'd0, 1'b0, 1'b1);
        line_change(eiec_pkg::MODE_LINE, 5'd31, 4'd0, 1'b1, 1'b0);
        line_change(eiec_pkg::MODE_LINE, 5'd3, 4'd0, 1'b1, 1'b1);
        line_change(eiec_pkg::MODE_GPIO, 5'd5, 4'd0, 1'b0, 1'b1);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_SEL1, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        line_change(eiec_pkg::MODE_GPIO, 5'd6, 4'd3, 1'b0, 1'b1);
        line_change(eiec_pkg::MODE_GPIO, 5'd7, 4'd15, 1'b1, 1'b0);
        line_change(eiec_pkg::MODE_GPIO, 5'd12, 4'd0, 1'b0, 1'b1);
        bus_access(eiec_pkg::MODE_READ, eiec_pkg::OFF_PEND, eiec_pkg::ACCESS_WORD, 32'h0);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_PEND, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_SWT, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_READ, eiec_pkg::OFF_SWT, eiec_pkg::ACCESS_WORD, 32'h0);
        bus_access(eiec_pkg::MODE_READ, eiec_pkg::OFF_RISE, 3'd0, 32'h0);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_RISE, 3'd7, 32'h0);
        bus_access(eiec_pkg::MODE_WRITE, 12'hFFF, eiec_pkg::ACCESS_WORD, 32'h0);
        bus_access(eiec_pkg::MODE_READ, 12'hFFC, eiec_pkg::ACCESS_WORD, 32'h0);
        bus_access(eiec_pkg::MODE_WRITE, 12'h010, eiec_pkg::ACCESS_WORD, 32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_EMASK, eiec_pkg::ACCESS_WORD,
                   32'hFFFF_FFFF);
        bus_access(eiec_pkg::MODE_READ, eiec_pkg::OFF_EMASK, eiec_pkg::ACCESS_WORD, 32'h0);
        bus_access(eiec_pkg::MODE_WRITE, eiec_pkg::OFF_IMASK, eiec_pkg::ACCESS_WORD, 32'h0);

        repeat (RANDOM_ITEMS) begin
            send_item(random_item());
        end
        in_ch.valid <= 1'b0;

        while (awaited != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        int  stall;
        logic held_off;
        held_off = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (!held_off && sent_count >= 600) begin
                stall    = LONG_HOLD;
                held_off = 1'b1;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
